/* rtl/core/ldps_pkg.sv */
// Package for the LED driver power sequencer.
// Holds the phase codes, configuration and payload types and reset constants.
// No dependencies; every other file of the block but ldps_stream_if imports it.
`timescale 1ns / 1ps

package ldps_pkg;

  // Default number of driver channels.
  localparam int ChannelsDefault = 2;

  // APB register map: four 32-bit registers at byte addresses 4*i.
  localparam int ApbAddrW = 4;
  localparam int ApbDataW = 32;

  // Configuration reset values.
  localparam logic [15:0] UvloThresholdRst = 16'd23000;
  localparam logic [31:0] FaultCooldownRst = 32'd1000000;
  localparam logic [31:0] RampCheckRst     = 32'd100000;
  localparam logic [7:0]  FaultLimitRst    = 8'd10;

  // Register indexes.
  typedef enum logic [1:0] {
    RegUvloThreshold = 2'd0,
    RegFaultCooldown = 2'd1,
    RegRampCheck     = 2'd2,
    RegFaultLimit    = 2'd3
  } cfg_reg_e;

  // Channel phases. Code 7 is never produced and is handled like off.
  typedef enum logic [2:0] {
    PhOff         = 3'd0,
    PhUvlo        = 3'd1,
    PhRamping     = 3'd2,
    PhEnabled     = 3'd3,
    PhDischarging = 3'd4,
    PhCooldown    = 3'd5,
    PhBlocked     = 3'd6
  } phase_e;

  typedef struct packed {
    logic [15:0] uvlo_threshold_mv;
    logic [31:0] fault_cooldown_us;
    logic [31:0] ramp_check_us;
    logic [7:0]  fault_max;
  } cfg_t;

  typedef struct packed {
    logic        channel;
    logic [10:0] drive_level;
    logic        status_pin;
    logic [15:0] vbus_mv;
    logic [62:0] now_us;
  } item_t;

  typedef struct packed {
    logic [2:0] new_state;
    logic       state_changed;
    logic       high_side_unlocked;
    logic       low_side_unlocked;
    logic [7:0] faults_seen;
  } result_t;

  // Per-channel sequencer state.
  typedef struct packed {
    phase_e      phase;
    logic [7:0]  faults;
    logic [63:0] deadline;
    logic        never;
  } chan_state_t;

endpackage

/* rtl/core/ldps_stream_if.sv */
// Valid/ready stream interface used by the sequencer's request and result channels.
// The payload type is a parameter; the block binds it to types from ldps_pkg.
`timescale 1ns / 1ps

interface ldps_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

/* rtl/core/ldps_cfg_regs.sv */
// APB configuration registers of the power sequencer.
// Depends on ldps_pkg for the register map, reset values and cfg_t.
`timescale 1ns / 1ps

module ldps_cfg_regs
  import ldps_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  cfg_reg_e reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_e'(paddr[ApbAddrW-1:2]);
  assign wr_en   = psel && penable && pwrite;

  // Write decode.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        RegUvloThreshold: cfg_d.uvlo_threshold_mv = pwdata[15:0];
        RegFaultCooldown: cfg_d.fault_cooldown_us = pwdata[31:0];
        RegRampCheck:     cfg_d.ramp_check_us     = pwdata[31:0];
        RegFaultLimit:    cfg_d.fault_max         = pwdata[7:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.uvlo_threshold_mv <= UvloThresholdRst;
      cfg_q.fault_cooldown_us <= FaultCooldownRst;
      cfg_q.ramp_check_us     <= RampCheckRst;
      cfg_q.fault_max         <= FaultLimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back.
  always_comb begin
    case (reg_sel)
      RegUvloThreshold: prdata = {16'b0, cfg_q.uvlo_threshold_mv};
      RegFaultCooldown: prdata = cfg_q.fault_cooldown_us;
      RegRampCheck:     prdata = cfg_q.ramp_check_us;
      RegFaultLimit:    prdata = {24'b0, cfg_q.fault_max};
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/core/ldps_step.sv */
// Next-state logic for one channel of the power sequencer.
// Purely combinational; depends on ldps_pkg for phase codes and struct types.
`timescale 1ns / 1ps

module ldps_step
  import ldps_pkg::*;
(
  input  item_t       item_i,
  input  chan_state_t state_i,
  input  cfg_t        cfg_i,
  output chan_state_t state_o,
  output result_t     result_o
);

  logic        requested;
  logic [63:0] now64;
  logic [31:0] delay;
  logic [63:0] deadline_new;
  logic        expired;
  logic        low_vbus;
  chan_state_t ramp_st;
  chan_state_t fault_st;
  chan_state_t nxt;

  assign requested = |item_i.drive_level;
  assign now64     = {1'b0, item_i.now_us};
  assign low_vbus  = item_i.vbus_mv < cfg_i.uvlo_threshold_mv;
  assign expired   = !state_i.never && (now64 > state_i.deadline);

  // Only a ramping channel can fault; off, UVLO, discharging and cooldown may start a ramp.
  assign delay        = (state_i.phase == PhRamping) ? cfg_i.fault_cooldown_us
                                                     : cfg_i.ramp_check_us;
  assign deadline_new = now64 + {32'b0, delay};

  // State after an attempt to start ramping.
  always_comb begin
    ramp_st = state_i;
    if (low_vbus) begin
      ramp_st.phase = PhUvlo;
    end else begin
      ramp_st.phase    = PhRamping;
      ramp_st.deadline = deadline_new;
      ramp_st.never    = 1'b0;
    end
  end

  // State after a fault: cool down while allowance remains, else block.
  always_comb begin
    fault_st = state_i;
    if (state_i.faults < cfg_i.fault_max) begin
      fault_st.phase    = PhCooldown;
      fault_st.deadline = deadline_new;
      fault_st.never    = 1'b0;
      fault_st.faults   = state_i.faults + 8'd1;
    end else begin
      fault_st.phase = PhBlocked;
      fault_st.never = 1'b1;
    end
  end

  // Phase transitions.
  always_comb begin
    nxt = state_i;
    case (state_i.phase)
      PhUvlo: begin
        if (!requested) nxt.phase = PhOff;
        else nxt = ramp_st;
      end
      PhRamping: begin
        if (!requested) nxt.phase = PhDischarging;
        else if (expired) nxt = item_i.status_pin ? fault_st : state_i;
        if (requested && expired && !item_i.status_pin) nxt.phase = PhEnabled;
      end
      PhEnabled: begin
        if (!requested) nxt.phase = PhDischarging;
        else if (low_vbus) nxt.phase = PhUvlo;
      end
      PhDischarging: begin
        if (requested) nxt = ramp_st;
        else if (!item_i.status_pin) nxt.phase = PhOff;
      end
      PhCooldown: begin
        if (!requested) nxt.phase = PhOff;
        else if (expired) nxt = ramp_st;
      end
      PhBlocked: begin
        if (!requested) nxt.phase = PhOff;
      end
      default: begin
        // Off, and the unused code: the fault count clears here.
        nxt.phase = PhOff;
        if (requested) nxt = ramp_st;
        nxt.faults = 8'd0;
      end
    endcase
  end

  assign state_o = nxt;

  // Result fields.
  always_comb begin
    result_o.new_state          = nxt.phase;
    result_o.state_changed      = nxt.phase != state_i.phase;
    result_o.high_side_unlocked = (nxt.phase == PhRamping) || (nxt.phase == PhEnabled);
    result_o.low_side_unlocked  = nxt.phase == PhEnabled;
    result_o.faults_seen        = nxt.faults;
  end

endmodule

/* rtl/core/led_driver_power_sequencer.sv */
// Top level of the LED driver power sequencer; uses ldps_pkg, ldps_cfg_regs, ldps_step.
// A request passes the request register and then the result register.
// Throughput: one request per cycle unless the result side stalls, also back to
// back on the same channel, since the channel state is read, updated and written in the same cycle.
// Reset (rst_ni, asynchronous, active low) sets every channel off with no faults
// and loads the default configuration.
`timescale 1ns / 1ps

module led_driver_power_sequencer
  import ldps_pkg::*;
#(
  parameter int NumChannels = ChannelsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  ldps_stream_if.sink         in_if,
  ldps_stream_if.source       out_if,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  localparam int ChIdxW = (NumChannels > 1) ? $clog2(NumChannels) : 1;

  cfg_t                          cfg;
  item_t                         in_q;
  logic                          in_vld_q;
  result_t                       out_q;
  logic                          out_vld_q;
  chan_state_t [NumChannels-1:0] st_q;
  chan_state_t                   st_cur;
  chan_state_t                   st_next;
  result_t                       step_res;
  result_t                       res_d;
  logic [ChIdxW-1:0]             idx;
  logic                          in_range;
  logic                          in_ready;
  logic                          advance;

  ldps_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Pipeline flow control: the request register drains whenever the
  // result register is empty or being taken.
  assign advance  = in_vld_q && (!out_vld_q || out_if.ready);
  assign in_ready = !in_vld_q || !out_vld_q || out_if.ready;
  assign in_if.ready = in_ready;

  // Request register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready) begin
      in_vld_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_ready) begin
      in_q <= in_if.payload;
    end
  end

  // Channel selection; out-of-range channels leave all state alone.
  assign in_range = 32'(in_q.channel) < 32'(NumChannels);
  assign idx      = in_range ? ChIdxW'(in_q.channel) : '0;
  assign st_cur   = st_q[idx];

  ldps_step u_step (
    .item_i   (in_q),
    .state_i  (st_cur),
    .cfg_i    (cfg),
    .state_o  (st_next),
    .result_o (step_res)
  );

  assign res_d = in_range ? step_res : '0;

  // Per-channel state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (advance && in_range) begin
      st_q[idx] <= st_next;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || out_if.ready) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res_d;
    end
  end

  assign out_if.valid   = out_vld_q;
  assign out_if.payload = out_q;

  // Low-side unlock is only ever granted together with high-side unlock.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (!out_q.low_side_unlocked || out_q.high_side_unlocked))
    else $error("low side unlocked without high side");

  // Channel state only moves when a request is evaluated.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(st_q))
    else $error("channel state changed without a request");

  // A held request stays in the request register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !advance) |=> (in_vld_q && $stable(in_q)))
    else $error("stalled request lost");

  // A new result appears only after a request advanced.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(advance))
    else $error("result appeared without a request");

endmodule
